// ===== rtl/vbs_pkg.sv =====
package vbs_pkg;

    // Fixed field widths of the channels
    localparam int PIX_W = 8;
    localparam int COL_W = 10;
    localparam int ROW_W = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_MATCHES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_RADIUS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSAMPLE_FACTOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED      = 3'd6;

    // Register reset values
    localparam logic [5:0]  RST_SAMPLE_COUNT     = 6'd20;
    localparam logic [5:0]  RST_REQUIRED_MATCHES = 6'd2;
    localparam logic [8:0]  RST_MATCH_RADIUS     = 9'd20;
    localparam logic [8:0]  RST_SUBSAMPLE_FACTOR = 9'd16;
    localparam logic [9:0]  RST_FRAME_WIDTH      = 10'd640;
    localparam logic [8:0]  RST_FRAME_HEIGHT     = 9'd480;
    localparam logic [31:0] RST_RANDOM_SEED      = 32'd1;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    // Galois LFSR, right shift
    function automatic logic [31:0] lfsr_step(logic [31:0] s);
        logic [31:0] n;
        n = s >> 1;
        if (s[0])
        begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

    // Scale upper 16 bits of the LFSR into [0, rng-1]
    function automatic logic [8:0] draw_scale(logic [15:0] r, logic [8:0] rng);
        logic [24:0] p;
        p = 25'(r) * 25'(rng);
        return p[24:16];
    endfunction

endpackage

// ===== rtl/vbs_pix_if.sv =====
interface vbs_pix_if
    import vbs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             init_model;

    modport source (output valid, pixel_value, column, row, init_model, input ready);
    modport sink   (input valid, pixel_value, column, row, init_model, output ready);
endinterface

// ===== rtl/vbs_res_if.sv =====
interface vbs_res_if
    import vbs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             is_foreground;
    logic [COL_W-1:0] out_column;
    logic [ROW_W-1:0] out_row;

    modport source (output valid, is_foreground, out_column, out_row, input ready);
    modport sink   (input valid, is_foreground, out_column, out_row, output ready);
endinterface

// ===== rtl/vbs_cfg_if.sv =====
interface vbs_cfg_if
    import vbs_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/vbs_ram.sv =====
module vbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/vibe_background_subtractor_unit.sv =====
// Out-of-frame and init items go from idle straight to done; others are read and
// classified, and a background item may update one of its own samples and one of
// a random neighbor's. One item at a time: the next item is taken only in idle,
// after any result stall. The pixel's RAM word is read, compared and, if its own
// sample is updated, written back; then the neighbor word may be read-modify-written.
// Reset clears control, loads config reset values and seed; sample RAM not cleared.
module vibe_background_subtractor_unit
    import vbs_pkg::*;
#(
    parameter int MAX_SAMPLES = 32,
    parameter int MAX_WIDTH   = 640,
    parameter int MAX_HEIGHT  = 480
) (
    input  logic      clk,
    input  logic      rst_n,
    vbs_pix_if.sink   pixel,
    vbs_res_if.source result,
    vbs_cfg_if.sink   cfg
);
    localparam int WORD_W = MAX_SAMPLES * PIX_W;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int SW     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int NW     = $clog2(MAX_SAMPLES + 1);
    localparam int XW0    = $clog2(MAX_WIDTH + 1) + 1;
    localparam int XW     = (XW0 > COL_W + 1) ? XW0 : COL_W + 1;
    localparam int YW0    = $clog2(MAX_HEIGHT + 1) + 1;
    localparam int YW     = (YW0 > ROW_W + 1) ? YW0 : ROW_W + 1;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_RD     = 9'b000000010,
        S_CLS    = 9'b000000100,
        S_OWN    = 9'b000001000,
        S_NBDRAW = 9'b000010000,
        S_NBSEL  = 9'b000100000,
        S_NBRD   = 9'b001000000,
        S_NBWR   = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Config registers and LFSR
    logic [5:0]  sample_count_reg, required_matches_reg;
    logic [8:0]  match_radius_reg, subsample_factor_reg, frame_height_reg;
    logic [9:0]  frame_width_reg;
    logic [31:0] lfsr_reg, lfsr_adv;
    logic        lfsr_step_en;

    // Item registers
    logic [PIX_W-1:0]       pix_reg;
    logic [COL_W-1:0]       col_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [AW-1:0]          addr_reg, nb_addr_reg, nb_addr_next;
    logic [WORD_W-1:0]      word_reg;
    logic [MAX_SAMPLES-1:0] match_reg;
    logic [SW-1:0]          idx_reg;
    logic                   fg_reg;

    // Output register
    logic             out_valid_reg;
    logic             out_fg_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;

    // RAM port
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    // Effective sizes
    logic [NW-1:0] n_eff;
    logic [XW-1:0] w_eff;
    logic [YW-1:0] h_eff;

    always_comb
    begin
        if (sample_count_reg == '0)
            n_eff = NW'(1);
        else if (32'(sample_count_reg) > 32'(MAX_SAMPLES))
            n_eff = NW'(MAX_SAMPLES);
        else
            n_eff = NW'(sample_count_reg);
        if (frame_width_reg == '0)
            w_eff = XW'(1);
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            w_eff = XW'(MAX_WIDTH);
        else
            w_eff = XW'(frame_width_reg);
        if (frame_height_reg == '0)
            h_eff = YW'(1);
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
            h_eff = YW'(MAX_HEIGHT);
        else
            h_eff = YW'(frame_height_reg);
    end

    // Input item checks and address
    logic          in_frame;
    logic [AW-1:0] in_addr;
    assign in_frame = (XW'(pixel.column) < w_eff) && (YW'(pixel.row) < h_eff);
    assign in_addr  = AW'(pixel.row) * AW'(MAX_WIDTH) + AW'(pixel.column);

    assign pixel.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    logic in_acc;
    assign in_acc = pixel.valid && pixel.ready;

    // Random draw: one LFSR advance per draw
    logic [8:0] draw_rng, draw_val;
    assign lfsr_adv = lfsr_step(lfsr_reg);
    assign draw_val = draw_scale(lfsr_adv[31:16], draw_rng);

    // Match vector from the RAM word
    logic [MAX_SAMPLES-1:0] match_vec;
    always_comb
    begin
        logic [PIX_W-1:0] s, d;
        for (int k = 0; k < MAX_SAMPLES; k++)
        begin
            s = ram_rdata[k*PIX_W +: PIX_W];
            d = (pix_reg > s) ? pix_reg - s : s - pix_reg;
            match_vec[k] = ({1'b0, d} < match_radius_reg) && (32'(k) < 32'(n_eff));
        end
    end

    // Match count and classification
    logic [NW-1:0] match_cnt;
    logic          is_bg;
    always_comb
    begin
        match_cnt = '0;
        for (int k = 0; k < MAX_SAMPLES; k++)
        begin
            match_cnt = match_cnt + NW'(match_reg[k]);
        end
    end
    assign is_bg = (7'(match_cnt) >= 7'(required_matches_reg));

    // Neighbors in raster order
    logic       up_ok, dn_ok, lf_ok, rt_ok;
    logic [7:0] nb_valid;
    logic [3:0] nb_cnt;
    logic [AW-1:0] nb_addr [8];
    assign up_ok = (row_reg != '0);
    assign dn_ok = (YW'(row_reg) + YW'(1)) < h_eff;
    assign lf_ok = (col_reg != '0);
    assign rt_ok = (XW'(col_reg) + XW'(1)) < w_eff;
    assign nb_valid = {dn_ok & rt_ok, dn_ok, dn_ok & lf_ok, rt_ok, lf_ok,
                       up_ok & rt_ok, up_ok, up_ok & lf_ok};
    assign nb_addr[0] = addr_reg - AW'(MAX_WIDTH) - AW'(1);
    assign nb_addr[1] = addr_reg - AW'(MAX_WIDTH);
    assign nb_addr[2] = addr_reg - AW'(MAX_WIDTH) + AW'(1);
    assign nb_addr[3] = addr_reg - AW'(1);
    assign nb_addr[4] = addr_reg + AW'(1);
    assign nb_addr[5] = addr_reg + AW'(MAX_WIDTH) - AW'(1);
    assign nb_addr[6] = addr_reg + AW'(MAX_WIDTH);
    assign nb_addr[7] = addr_reg + AW'(MAX_WIDTH) + AW'(1);

    always_comb
    begin
        nb_cnt = '0;
        for (int j = 0; j < 8; j++)
        begin
            nb_cnt = nb_cnt + 4'(nb_valid[j]);
        end
    end

    // Pick the sel-th valid neighbor
    always_comb
    begin
        logic [3:0] sel, run;
        sel = (draw_val >= 9'(nb_cnt)) ? nb_cnt - 4'd1 : draw_val[3:0];
        run = '0;
        nb_addr_next = nb_addr[0];
        for (int j = 0; j < 8; j++)
        begin
            if (nb_valid[j])
            begin
                if (run == sel)
                    nb_addr_next = nb_addr[j];
                run = run + 4'd1;
            end
        end
    end

    // Next state, draw range and RAM control
    always_comb
    begin
        state_next   = state_reg;
        draw_rng     = subsample_factor_reg;
        lfsr_step_en = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = word_reg;
        ram_re       = 1'b0;
        ram_raddr    = in_addr;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (!in_frame)
                        state_next = S_DONE;
                    else if (pixel.init_model)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = in_addr;
                        ram_wdata  = {MAX_SAMPLES{pixel.pixel_value}};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
                state_next = S_CLS;
            S_CLS:
            begin
                if (!is_bg)
                    state_next = S_DONE;
                else
                begin
                    lfsr_step_en = 1'b1;
                    state_next   = (draw_val == '0) ? S_OWN : S_NBDRAW;
                end
            end
            S_OWN:
            begin
                draw_rng     = 9'(n_eff);
                lfsr_step_en = 1'b1;
                ram_we       = 1'b1;
                ram_wdata[32'(draw_val[SW-1:0])*PIX_W +: PIX_W] = pix_reg;
                state_next   = S_NBDRAW;
            end
            S_NBDRAW:
            begin
                lfsr_step_en = 1'b1;
                state_next   = (draw_val == '0 && nb_cnt != '0) ? S_NBSEL : S_DONE;
            end
            S_NBSEL:
            begin
                draw_rng     = 9'(nb_cnt);
                lfsr_step_en = 1'b1;
                state_next   = S_NBRD;
            end
            S_NBRD:
            begin
                draw_rng     = 9'(n_eff);
                lfsr_step_en = 1'b1;
                ram_re       = 1'b1;
                ram_raddr    = nb_addr_reg;
                state_next   = S_NBWR;
            end
            S_NBWR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = nb_addr_reg;
                ram_wdata  = ram_rdata;
                ram_wdata[32'(idx_reg)*PIX_W +: PIX_W] = pix_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control state, config and LFSR
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            out_valid_reg        <= 1'b0;
            sample_count_reg     <= RST_SAMPLE_COUNT;
            required_matches_reg <= RST_REQUIRED_MATCHES;
            match_radius_reg     <= RST_MATCH_RADIUS;
            subsample_factor_reg <= RST_SUBSAMPLE_FACTOR;
            frame_width_reg      <= RST_FRAME_WIDTH;
            frame_height_reg     <= RST_FRAME_HEIGHT;
            lfsr_reg             <= RST_RANDOM_SEED;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && (!out_valid_reg || result.ready))
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (lfsr_step_en)
                lfsr_reg <= lfsr_adv;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_SAMPLE_COUNT:     sample_count_reg     <= cfg.data[5:0];
                    CFG_REQUIRED_MATCHES: required_matches_reg <= cfg.data[5:0];
                    CFG_MATCH_RADIUS:     match_radius_reg     <= cfg.data[8:0];
                    CFG_SUBSAMPLE_FACTOR: subsample_factor_reg <= cfg.data[8:0];
                    CFG_FRAME_WIDTH:      frame_width_reg      <= cfg.data[9:0];
                    CFG_FRAME_HEIGHT:     frame_height_reg     <= cfg.data[8:0];
                    CFG_RANDOM_SEED:      lfsr_reg <= (cfg.data != '0) ? cfg.data : 32'd1;
                    default:              ;
                endcase
            end
        end
    end

    // Item payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pix_reg  <= pixel.pixel_value;
            col_reg  <= pixel.column;
            row_reg  <= pixel.row;
            addr_reg <= in_addr;
            fg_reg   <= !in_frame;
        end
        if (state_reg == S_RD)
        begin
            word_reg  <= ram_rdata;
            match_reg <= match_vec;
        end
        if (state_reg == S_CLS)
            fg_reg <= !is_bg;
        if (state_reg == S_NBSEL)
            nb_addr_reg <= nb_addr_next;
        if (state_reg == S_NBRD)
            idx_reg <= draw_val[SW-1:0];
        if (state_reg == S_DONE && (!out_valid_reg || result.ready))
        begin
            out_fg_reg  <= fg_reg;
            out_col_reg <= col_reg;
            out_row_reg <= row_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.is_foreground = out_fg_reg;
    assign result.out_column    = out_col_reg;
    assign result.out_row       = out_row_reg;

    // Sample store: one word holds all samples of one pixel
    vbs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_sample_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule

// ===== test/tb_vibe_background_subtractor_unit.sv =====
module tb_vibe_background_subtractor_unit;
    import vbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_COLS = 640;
    localparam int FRAME_ROWS = 480;
    localparam int SLOTS = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 280;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             init;
    } pixel_item_t;

    typedef struct {
        logic             fg;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } class_result_t;

    // Mirror of the block: registers, sample words, LFSR and pending results
    class vbs_scoreboard;
        logic [5:0]  n_samples;
        logic [5:0]  n_required;
        logic [8:0]  radius;
        logic [8:0]  subsample;
        logic [9:0]  width_reg;
        logic [8:0]  height_reg;
        logic [31:0] lfsr;
        logic [255:0] samples [int];
        bit primed [int];
        class_result_t pending [$];

        function new();
            n_samples  = RST_SAMPLE_COUNT;
            n_required = RST_REQUIRED_MATCHES;
            radius     = RST_MATCH_RADIUS;
            subsample  = RST_SUBSAMPLE_FACTOR;
            width_reg  = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            lfsr       = RST_RANDOM_SEED;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > FRAME_COLS) return FRAME_COLS;
            return 32'(width_reg);
        endfunction

        function int unsigned eff_height();
            if (height_reg == 0) return 1;
            if (height_reg > FRAME_ROWS) return FRAME_ROWS;
            return 32'(height_reg);
        endfunction

        function int unsigned eff_samples();
            if (n_samples == 0) return 1;
            if (n_samples > SLOTS) return SLOTS;
            return 32'(n_samples);
        endfunction

        function int unsigned draw(int unsigned rng);
            logic lsb;
            lsb = lfsr[0];
            lfsr = lfsr >> 1;
            if (lsb)
            begin
                lfsr = lfsr ^ LFSR_TAPS;
            end
            return ((lfsr >> 16) * rng) >> 16;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_SAMPLE_COUNT:     n_samples = data[5:0];
                CFG_REQUIRED_MATCHES: n_required = data[5:0];
                CFG_MATCH_RADIUS:     radius = data[8:0];
                CFG_SUBSAMPLE_FACTOR: subsample = data[8:0];
                CFG_FRAME_WIDTH:      width_reg = data[9:0];
                CFG_FRAME_HEIGHT:     height_reg = data[8:0];
                CFG_RANDOM_SEED:      lfsr = (data != 0) ? data : 32'd1;
                default: ;
            endcase
        endfunction

        function void put_sample(int key, int unsigned k, logic [7:0] v);
            logic [255:0] w;
            w = samples.exists(key) ? samples[key] : '0;
            w[8*k +: 8] = v;
            samples[key] = w;
        endfunction

        function logic [7:0] get_sample(int key, int unsigned k);
            logic [255:0] w;
            w = samples.exists(key) ? samples[key] : '0;
            return w[8*k +: 8];
        endfunction

        // Classify one accepted pixel and apply its model updates
        function void note_input(pixel_item_t it);
            class_result_t r;
            int key;
            int unsigned w, h, n, cnt, k, d, s, idx, sel;
            int nx [8];
            int ny [8];
            int x, y;
            w = eff_width();
            h = eff_height();
            n = eff_samples();
            key = int'(it.row) * 1024 + int'(it.col);
            r.fg = 1'b1;
            r.col = it.col;
            r.row = it.row;
            if (it.col < w && it.row < h)
            begin
                if (it.init)
                begin
                    samples[key] = {SLOTS{it.pix}};
                    primed[key] = 1'b1;
                    r.fg = 1'b0;
                end
                else
                begin
                    cnt = 0;
                    k = 0;
                    while (cnt < n_required && k < n)
                    begin
                        s = 32'(get_sample(key, k));
                        d = (it.pix > s) ? it.pix - s : s - it.pix;
                        if (d < radius) cnt++;
                        k++;
                    end
                    if (cnt >= n_required)
                    begin
                        r.fg = 1'b0;
                        if (draw(subsample) == 0)
                        begin
                            idx = draw(n);
                            put_sample(key, idx, it.pix);
                        end
                        if (draw(subsample) == 0)
                        begin
                            cnt = 0;
                            for (int dy = -1; dy <= 1; dy++)
                            begin
                                for (int dx = -1; dx <= 1; dx++)
                                begin
                                    x = int'(it.col) + dx;
                                    y = int'(it.row) + dy;
                                    if (!(dx == 0 && dy == 0) && x >= 0 && y >= 0
                                        && x < int'(w) && y < int'(h))
                                    begin
                                        nx[cnt] = x;
                                        ny[cnt] = y;
                                        cnt++;
                                    end
                                end
                            end
                            if (cnt > 0)
                            begin
                                sel = draw(cnt);
                                if (sel >= cnt) sel = cnt - 1;
                                idx = draw(n);
                                put_sample(ny[sel] * 1024 + nx[sel], idx, it.pix);
                            end
                        end
                    end
                end
            end
            pending.push_back(r);
        endfunction

        // Returns the number of wrong fields; -1 when nothing was pending
        function int check_result(logic fg, logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                                  output string msg);
            class_result_t e;
            int bad;
            msg = "";
            if (pending.size() == 0)
            begin
                $sformat(msg, "unexpected result fg=%0d col=%0d row=%0d", fg, col, row);
                return -1;
            end
            e = pending.pop_front();
            bad = 0;
            if (fg !== e.fg) bad++;
            if (col !== e.col) bad++;
            if (row !== e.row) bad++;
            if (bad > 0)
                $sformat(msg, "result mismatch: got fg=%0d col=%0d row=%0d, want %0d %0d %0d",
                         fg, col, row, e.fg, e.col, e.row);
            return bad;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   errors;
    int   cycles;

    vbs_pix_if pix_ch ();
    vbs_res_if res_ch ();
    vbs_cfg_if cfg_ch ();

    vibe_background_subtractor_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix_ch.sink),
        .result (res_ch.source),
        .cfg    (cfg_ch.sink)
    );

    vbs_scoreboard sb;
    bit no_gaps;

    task automatic report_mismatch(string msg);
        $display("tb: mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Timeout guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result sink with random stalls
    initial
    begin
        int run;
        bit level;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            case ($urandom_range(0, 19))
                0:       begin level = 1'b0; run = $urandom_range(10, 40); end
                1, 2, 3,
                4, 5:    begin level = 1'b0; run = $urandom_range(1, 3); end
                default: begin level = 1'b1; run = $urandom_range(1, 30); end
            endcase
            if (no_gaps) level = 1'b1;
            repeat (run)
            begin
                res_ch.ready <= level;
                @(posedge clk);
            end
        end
    end

    // Result check
    always @(posedge clk)
    begin
        string msg;
        int bad;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            bad = sb.check_result(res_ch.is_foreground, res_ch.out_column, res_ch.out_row,
                                  msg);
            if (bad != 0) report_mismatch(msg);
        end
    end

    task automatic send_pixel(pixel_item_t it);
        int gap;
        case ($urandom_range(0, 19))
            0:             gap = $urandom_range(10, 40);
            1, 2, 3, 4, 5,
            6, 7:          gap = $urandom_range(1, 3);
            default:       gap = 0;
        endcase
        if (no_gaps) gap = 0;
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_value <= it.pix;
        pix_ch.column      <= it.col;
        pix_ch.row         <= it.row;
        pix_ch.init_model  <= it.init;
        @(posedge clk);
        while (!pix_ch.ready) @(posedge clk);
        sb.note_input(it);
    endtask

    // Register write, only once the block has drained
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        pix_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic set_regs(int sc, int rm, int rad, int sub, int w, int h,
                            logic [31:0] seed);
        write_reg(CFG_SAMPLE_COUNT, sc);
        write_reg(CFG_REQUIRED_MATCHES, rm);
        write_reg(CFG_MATCH_RADIUS, rad);
        write_reg(CFG_SUBSAMPLE_FACTOR, sub);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_RANDOM_SEED, seed);
    endtask

    function automatic pixel_item_t make_item(int pix, int col, int row, bit init);
        pixel_item_t it;
        it.pix = PIX_W'(pix);
        it.col = COL_W'(col);
        it.row = ROW_W'(row);
        it.init = init;
        return it;
    endfunction

    // Random item: mostly classify primed pixels near their stored values
    function automatic pixel_item_t random_item();
        pixel_item_t it;
        int key, k, v, sel;
        sel = $urandom_range(0, 99);
        it.pix = PIX_W'($urandom_range(0, 255));
        it.init = 1'b0;
        if ($urandom_range(0, 3) == 0) it.col = COL_W'($urandom_range(634, 639));
        else it.col = COL_W'($urandom_range(0, 5));
        if ($urandom_range(0, 3) == 0) it.row = ROW_W'($urandom_range(475, 479));
        else it.row = ROW_W'($urandom_range(0, 4));
        if (sel >= 88)
        begin
            it.col = COL_W'($urandom_range(0, 1023));
            it.row = ROW_W'($urandom_range(0, 511));
            it.init = 1'($urandom_range(0, 1));
        end
        else if (sel < 10)
        begin
            it.init = 1'b1;
        end
        key = int'(it.row) * 1024 + int'(it.col);
        // An unprimed in-frame pixel must never be scanned
        if (!it.init && it.col < sb.eff_width() && it.row < sb.eff_height()
            && !sb.primed.exists(key))
            it.init = 1'b1;
        if (!it.init && sb.primed.exists(key) && $urandom_range(0, 4) != 0)
        begin
            k = $urandom_range(0, SLOTS - 1);
            v = int'(sb.get_sample(key, k)) + $urandom_range(0, 60) - 30;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            it.pix = PIX_W'(v);
        end
        return it;
    endfunction

    task automatic random_phase(int count);
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (count) send_pixel(random_item());
        no_gaps = 1'b0;
    endtask

    // Main sequence
    initial
    begin
        errors = 0;
        cycles = 0;
        no_gaps = 1'b0;
        sb = new();
        rst_n = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel_value = '0;
        pix_ch.column = '0;
        pix_ch.row = '0;
        pix_ch.init_model = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, field extremes, init and out of frame
        send_pixel(make_item(0, 0, 0, 1));
        send_pixel(make_item(0, 0, 0, 0));
        send_pixel(make_item(255, 0, 0, 0));
        send_pixel(make_item(255, 639, 479, 1));
        send_pixel(make_item(255, 639, 479, 0));
        send_pixel(make_item(0, 639, 479, 0));
        send_pixel(make_item(240, 639, 479, 0));
        send_pixel(make_item(10, 640, 0, 0));
        send_pixel(make_item(10, 0, 480, 1));
        send_pixel(make_item(255, 1023, 511, 1));
        send_pixel(make_item(128, 384, 256, 1));
        send_pixel(make_item(127, 384, 256, 0));
        // Index past the register list is ignored
        write_reg(3'd7, 32'hFFFF_FFFF);
        send_pixel(make_item(128, 384, 256, 0));
        random_phase(PHASE_ITEMS - 13);

        // Every update taken
        set_regs(20, 2, 20, 1, 640, 480, 32'hDEAD_BEEF);
        random_phase(PHASE_ITEMS);
        // 1x1 frame, zero seed, zero subsample factor
        set_regs(1, 1, 256, 0, 1, 1, 32'h0);
        send_pixel(make_item(7, 0, 0, 1));
        send_pixel(make_item(200, 0, 0, 0));
        send_pixel(make_item(7, 1, 0, 0));
        random_phase(PHASE_ITEMS - 3);
        // Upper extremes
        set_regs(32, 32, 256, 256, 2, 3, 32'hFFFF_FFFF);
        random_phase(PHASE_ITEMS);
        // Zero matches required, zero radius, zero samples
        set_regs(0, 0, 0, 2, 6, 5, $urandom());
        random_phase(PHASE_ITEMS);
        // Oversized values are clamped; more matches than samples
        set_regs(63, 40, 100, 4, 1023, 511, $urandom() | 32'd1);
        random_phase(PHASE_ITEMS);
        set_regs(8, 3, 30, 2, 6, 5, $urandom());
        random_phase(PHASE_ITEMS);
        set_regs(20, 2, 20, 16, 640, 480, $urandom());
        random_phase(PHASE_ITEMS);

        pix_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
